/* rtl/core/dgsb_pkg.sv */
// Shared types and constants for the delta good-suffix table builder.
// No dependencies; used by every file in rtl/core.
package dgsb_pkg;

  localparam int SYMBOL_W   = 8;
  localparam int POSITION_W = 6;
  localparam int SHIFT_W    = 7;
  localparam int DELTA_W    = 8;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // register index, decoded from paddr[PADDR_W-1:2]
  localparam logic [PADDR_W-3:0] REG_DELTA = 1'b0;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol_value;
    logic                pattern_end;
  } symbol_t;

  typedef struct packed {
    logic [POSITION_W-1:0] position;
    logic [SHIFT_W-1:0]    shift;
    logic                  table_last;
  } result_t;

  typedef struct packed {
    logic load;
    logic build_start;
    logic jj_inc;
    logic suf_store;
    logic k_inc;
    logic put;
    logic shift_mode;
  } dgsb_cmd_t;

  typedef struct packed {
    logic m_one;
    logic jj_gt_i;
    logic i_zero;
    logic sym_match;
    logic k_at_m;
    logic k_ok;
    logic last_pos;
    logic out_free;
  } dgsb_sts_t;

endpackage

/* rtl/core/delta_good_suffix_builder_top.sv */
// Top level: APB delta register, controller and datapath.
// Depends on dgsb_pkg, dgsb_controller, dgsb_datapath.
//
// Usage: pattern symbols arrive on the symbol channel (valid/stall), one beat
// per cycle while the block is loading; the beat with pattern_end set closes
// the pattern. Symbols beyond MAX_PATTERN are dropped, the closing beat still
// starts the build. The block then stalls the symbol channel and emits one
// result beat per pattern position 0..m-1, table_last on the final one.
// Build: a start step, a suffix pass, then a shift search per position that
// ends in a put; each compare step is a registered read of the pattern and
// suffix memories, then an evaluate. Loading runs at one symbol per cycle.
// Results leave through an output register; a stalled result holds and the
// search waits. The next pattern may start loading while the last result
// still waits. The user must see that delta is written over APB only while
// idle; the block itself does not enforce it.
// Reset: synchronous, clears the symbol count, delta, FSM and output valid.
module delta_good_suffix_builder_top #(
  parameter int MAX_PATTERN = 64,
  parameter int VALUE_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          symbol_valid,
  output logic                          symbol_stall,
  input  dgsb_pkg::symbol_t             symbol,
  output logic                          result_valid,
  input  logic                          result_stall,
  output dgsb_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dgsb_pkg::PADDR_W-1:0]  paddr,
  input  logic [dgsb_pkg::PDATA_W-1:0]  pwdata,
  output logic [dgsb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import dgsb_pkg::*;

  logic [DELTA_W-1:0] delta;
  logic               sel_delta;
  dgsb_cmd_t          cmd;
  dgsb_sts_t          sts;

  assign pready    = 1'b1;
  assign sel_delta = paddr[PADDR_W-1:2] == REG_DELTA;
  assign prdata    = sel_delta ? PDATA_W'(delta) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      delta <= '0;
    end else if (psel && penable && pwrite && pready && sel_delta) begin
      delta <= pwdata[DELTA_W-1:0];
    end
  end

  dgsb_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .symbol_valid (symbol_valid),
    .pattern_end  (symbol.pattern_end),
    .sts          (sts),
    .symbol_stall (symbol_stall),
    .cmd          (cmd)
  );

  dgsb_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .symbol       (symbol),
    .delta        (delta),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .sts          (sts)
  );

endmodule

/* rtl/core/dgsb_datapath.sv */
// Datapath: pattern and suffix memories, loop counters, compares, result register.
// Depends on dgsb_pkg; driven by dgsb_controller commands.
module dgsb_datapath #(
  parameter int MAX_PATTERN = 64,
  parameter int VALUE_BITS  = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dgsb_pkg::dgsb_cmd_t            cmd,
  input  dgsb_pkg::symbol_t              symbol,
  input  logic [dgsb_pkg::DELTA_W-1:0]   delta,
  input  logic                           result_stall,
  output logic                           result_valid,
  output dgsb_pkg::result_t              result,
  output dgsb_pkg::dgsb_sts_t            sts
);
  import dgsb_pkg::*;

  localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int TW = DELTA_W + 1;
  localparam int DW = (VALUE_BITS > TW) ? VALUE_BITS : TW;

  logic [VALUE_BITS-1:0] pmem [MAX_PATTERN];
  logic [AW-1:0]         smem [MAX_PATTERN];

  logic [CW-1:0] count;
  logic [AW-1:0] i;
  logic [AW-1:0] jj;
  logic [AW-1:0] j;
  logic [CW-1:0] k;

  logic [VALUE_BITS-1:0] rd_a;
  logic [VALUE_BITS-1:0] rd_b;
  logic [AW-1:0]         rd_s;

  logic [VALUE_BITS-1:0] sym;
  logic [CW-1:0]         suf_a_full;
  logic [CW-1:0]         suf_s_full;
  logic [CW-1:0]         start_i_full;
  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;
  logic [VALUE_BITS-1:0] diff;
  logic [CW-1:0]         rem_j;
  logic [CW-1:0]         rem_k;
  logic [CW-1:0]         need;
  logic                  k_lt_j;

  assign sym          = VALUE_BITS'({{32{1'b0}}, symbol.symbol_value});
  assign suf_a_full   = count - CW'(1) - CW'(jj);
  assign suf_s_full   = count - k - CW'(1);
  assign start_i_full = count - CW'(2);

  always_comb begin
    if (cmd.shift_mode) begin
      addr_a = j - AW'(1);
      addr_b = j - AW'(1) - AW'(k);
    end else begin
      addr_a = suf_a_full[AW-1:0];
      addr_b = i - jj;
    end
  end

  always_ff @(posedge clk) begin
    rd_a <= pmem[addr_a];
    rd_b <= pmem[addr_b];
    rd_s <= smem[suf_s_full[AW-1:0]];
    if (cmd.load && (count != CW'(MAX_PATTERN))) begin
      pmem[count[AW-1:0]] <= sym;
    end
    if (cmd.suf_store) begin
      smem[i] <= jj;
    end
  end

  assign diff   = (rd_a > rd_b) ? (rd_a - rd_b) : (rd_b - rd_a);
  assign rem_j  = count - CW'(j);
  assign rem_k  = count - k;
  assign need   = (rem_j < rem_k) ? rem_j : rem_k;
  assign k_lt_j = k < CW'(j);

  always_comb begin
    sts.m_one     = count == CW'(1);
    sts.jj_gt_i   = jj > i;
    sts.i_zero    = i == '0;
    sts.sym_match = DW'(diff) <= DW'({delta, 1'b0});
    sts.k_at_m    = k == count;
    sts.k_ok      = !(k_lt_j && (rd_a == rd_b)) && (need <= CW'(rd_s));
    sts.last_pos  = CW'(j) == (count - CW'(1));
    sts.out_free  = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && (count != CW'(MAX_PATTERN))) begin
      count <= count + CW'(1);
    end else if (cmd.put && sts.last_pos) begin
      count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      i <= start_i_full[AW-1:0];
      jj <= '0;
      j <= '0;
      k <= CW'(1);
    end else begin
      if (cmd.jj_inc) begin
        jj <= jj + AW'(1);
      end
      if (cmd.suf_store) begin
        i <= i - AW'(1);
        jj <= '0;
      end
      if (cmd.k_inc) begin
        k <= k + CW'(1);
      end
      if (cmd.put) begin
        j <= j + AW'(1);
        k <= CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.put) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      result.position   <= POSITION_W'(j);
      result.shift      <= SHIFT_W'(k);
      result.table_last <= sts.last_pos;
    end
  end

endmodule

/* rtl/core/dgsb_controller.sv */
// Controller FSM: load, suffix build, shift search and result hand-off.
// Depends on dgsb_pkg; steers dgsb_datapath through command/status structs.
module dgsb_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  symbol_valid,
  input  logic                  pattern_end,
  input  dgsb_pkg::dgsb_sts_t   sts,
  output logic                  symbol_stall,
  output dgsb_pkg::dgsb_cmd_t   cmd
);
  import dgsb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_START  = 3'd1;
  localparam logic [2:0] S_SUF_RD = 3'd2;
  localparam logic [2:0] S_SUF_EV = 3'd3;
  localparam logic [2:0] S_SH_RD  = 3'd4;
  localparam logic [2:0] S_SH_EV  = 3'd5;
  localparam logic [2:0] S_PUT    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign symbol_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (symbol_valid) begin
          cmd.load = 1'b1;
          if (pattern_end) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.build_start = 1'b1;
        state_next      = sts.m_one ? S_SH_RD : S_SUF_RD;
      end
      S_SUF_RD: begin
        if (sts.jj_gt_i) begin
          cmd.suf_store = 1'b1;
          state_next    = sts.i_zero ? S_SH_RD : S_SUF_RD;
        end else begin
          state_next = S_SUF_EV;
        end
      end
      S_SUF_EV: begin
        if (sts.sym_match) begin
          cmd.jj_inc = 1'b1;
          state_next = S_SUF_RD;
        end else begin
          cmd.suf_store = 1'b1;
          state_next    = sts.i_zero ? S_SH_RD : S_SUF_RD;
        end
      end
      S_SH_RD: begin
        cmd.shift_mode = 1'b1;
        state_next     = sts.k_at_m ? S_PUT : S_SH_EV;
      end
      S_SH_EV: begin
        cmd.shift_mode = 1'b1;
        if (sts.k_ok) begin
          state_next = S_PUT;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_SH_RD;
        end
      end
      S_PUT: begin
        cmd.shift_mode = 1'b1;
        if (sts.out_free) begin
          cmd.put    = 1'b1;
          state_next = sts.last_pos ? S_IDLE : S_SH_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/dgsb_checker.sv */
// Port-level checks for the good-suffix builder, bound to the top level.
// Depends on dgsb_pkg.
module dgsb_checker (
  input logic              clk,
  input logic              rst,
  input logic              symbol_valid,
  input logic              symbol_stall,
  input dgsb_pkg::symbol_t symbol,
  input logic              result_valid,
  input logic              result_stall,
  input dgsb_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  a_build_stalls: assert property (@(posedge clk) disable iff (rst)
    symbol_valid && !symbol_stall && symbol.pattern_end |=> symbol_stall)
    else $error("closing symbol beat did not start the build");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.shift != '0)
    else $error("zero shift reported");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid && !symbol_stall)
    else $error("block not idle after reset");

endmodule

bind delta_good_suffix_builder_top dgsb_checker u_dgsb_checker (
  .clk          (clk),
  .rst          (rst),
  .symbol_valid (symbol_valid),
  .symbol_stall (symbol_stall),
  .symbol       (symbol),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
